FILE: design/hlmdq_pkg.sv
// Shared types, sizes and word layouts for the hub-label distance query core.
`timescale 1ns / 1ps
`default_nettype none

package hlmdq_pkg;

   // Sizing of the label stores and the distance arithmetic.
   localparam int NUM_VERTICES = 1024;
   localparam int MAX_LABELS   = 64;
   localparam int DIST_BITS    = 24;

   // Fixed field widths of the request and response words.
   localparam int OP_W   = 2;
   localparam int VERT_W = 10;
   localparam int RANK_W = 10;

   // Derived widths.
   localparam int VIDX_W  = $clog2(NUM_VERTICES);
   localparam int LBL_W   = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
   localparam int CNT_W   = $clog2(MAX_LABELS + 1);
   localparam int LADDR_W = VIDX_W + LBL_W;
   localparam int LDEPTH  = 2 ** LADDR_W;
   localparam int SUM_W   = DIST_BITS + 1;

   // Request word layout, lowest bits first.
   localparam int VA_LSB    = 0;
   localparam int VB_LSB    = VA_LSB + VERT_W;
   localparam int HUB_LSB   = VB_LSB + VERT_W;
   localparam int HDIST_LSB = HUB_LSB + VERT_W;
   localparam int RANK_LSB  = HDIST_LSB + DIST_BITS;
   localparam int REQ_BITS  = RANK_LSB + RANK_W;
   localparam int REQ_W     = ((REQ_BITS + 7) / 8) * 8;

   // Response word layout, lowest bits first.
   localparam int FOUND_POS  = SUM_W;
   localparam int STATUS_POS = SUM_W + 1;
   localparam int RSP_W      = ((SUM_W + 2 + 7) / 8) * 8;

   localparam logic [SUM_W-1:0] SUM_ALL_ONES = '1;

   typedef enum logic [OP_W-1:0] {
      OP_SET_RANK = 2'd0,
      OP_APPEND   = 2'd1,
      OP_CLEAR    = 2'd2,
      OP_QUERY    = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_APP_RD,
      ST_APP_WR,
      ST_Q_LEN,
      ST_Q_INIT,
      ST_Q_FETCH,
      ST_Q_HUB,
      ST_Q_STEP,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_item;
      logic wr_rank;
      logic wr_clear;
      logic clr_sweep;
      logic app_commit;
      logic q_init;
      logic q_latch;
      logic q_step;
      logic load_rsp;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      op_type op;
      logic   more;
      logic   clr_last;
      logic   rsp_free;
   } dp_stat_type;

endpackage

`default_nettype wire

FILE: design/hlmdq_ram.sv
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module hlmdq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic      [WIDTH-1:0]         rd_data_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // Write port and both registered read ports.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

FILE: design/hlmdq_ctrl.sv
// Controller state machine that sequences updates, the list merge and the response.
`timescale 1ns / 1ps
`default_nettype none

module hlmdq_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   input  wire logic [hlmdq_pkg::OP_W-1:0] req_op,
   output logic                      req_tready,
   input  wire hlmdq_pkg::dp_stat_type stat,
   output hlmdq_pkg::dp_cmd_type     cmd
);
   import hlmdq_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_sweep = 1'b1;
            if (stat.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               case (op_type'(req_op))
                  OP_APPEND: state_in = ST_APP_RD;
                  OP_QUERY:  state_in = ST_Q_LEN;
                  default:   state_in = ST_EXEC;
               endcase
            end
         end
         ST_EXEC: begin
            cmd.wr_rank  = (stat.op == OP_SET_RANK);
            cmd.wr_clear = (stat.op == OP_CLEAR);
            state_in     = ST_DONE;
         end
         ST_APP_RD: begin
            state_in = ST_APP_WR;
         end
         ST_APP_WR: begin
            cmd.app_commit = 1'b1;
            state_in       = ST_DONE;
         end
         ST_Q_LEN: begin
            state_in = ST_Q_INIT;
         end
         ST_Q_INIT: begin
            cmd.q_init = 1'b1;
            state_in   = ST_Q_FETCH;
         end
         ST_Q_FETCH: begin
            if (stat.more) begin
               state_in = ST_Q_HUB;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_Q_HUB: begin
            cmd.q_latch = 1'b1;
            state_in    = ST_Q_STEP;
         end
         ST_Q_STEP: begin
            cmd.q_step = 1'b1;
            state_in   = ST_Q_FETCH;
         end
         ST_DONE: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: design/hlmdq_dpath.sv
// Datapath: label, rank and count stores, merge registers and response register.
`timescale 1ns / 1ps
`default_nettype none

module hlmdq_dpath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [hlmdq_pkg::OP_W-1:0]    req_tuser,
   input  wire logic [hlmdq_pkg::REQ_W-1:0]   req_tdata,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic      [hlmdq_pkg::RSP_W-1:0]   rsp_tdata,
   input  wire hlmdq_pkg::dp_cmd_type         cmd,
   output hlmdq_pkg::dp_stat_type             stat
);
   import hlmdq_pkg::*;

   // Latched request item.
   op_type                 op_ff, op_in;
   logic [VERT_W-1:0]      va_ff, va_in;
   logic [VERT_W-1:0]      vb_ff, vb_in;
   logic [VERT_W-1:0]      hub_ff, hub_in;
   logic [DIST_BITS-1:0]   hd_ff, hd_in;
   logic [RANK_W-1:0]      rank_ff, rank_in;

   // Merge state.
   logic [CNT_W-1:0]       na_ff, na_in;
   logic [CNT_W-1:0]       nb_ff, nb_in;
   logic [CNT_W-1:0]       i_ff, i_in;
   logic [CNT_W-1:0]       j_ff, j_in;
   logic [VERT_W-1:0]      ha_ff, ha_in;
   logic [VERT_W-1:0]      hb_ff, hb_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [SUM_W-1:0]       best_ff, best_in;
   logic                   found_ff, found_in;
   logic                   status_ff, status_in;

   // Reset sweep counter and response register.
   logic [VIDX_W-1:0]      clr_cnt_ff, clr_cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]       rsp_dist_ff, rsp_dist_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic                   rsp_status_ff, rsp_status_in;

   // Memory ports.
   logic [VIDX_W-1:0]      va_idx, vb_idx;
   logic                   va_ok, ha_ok, hb_ok;
   logic [CNT_W-1:0]       cnt_rd_a, cnt_rd_b;
   logic                   cnt_we;
   logic [VIDX_W-1:0]      cnt_waddr;
   logic [CNT_W-1:0]       cnt_wdata;
   logic                   full;
   logic                   lbl_we;
   logic [LADDR_W-1:0]     lbl_waddr;
   logic [LADDR_W-1:0]     lbl_raddr_a, lbl_raddr_b;
   logic [VERT_W-1:0]      hub_rd_a, hub_rd_b;
   logic [DIST_BITS-1:0]   dist_rd_a, dist_rd_b;
   logic [RANK_W-1:0]      rank_rd_a, rank_rd_b;
   logic [RANK_W-1:0]      rank_a, rank_b;

   assign va_idx = VIDX_W'(va_ff);
   assign vb_idx = VIDX_W'(vb_ff);
   assign va_ok  = (32'(va_ff) < NUM_VERTICES);
   assign ha_ok  = (32'(ha_ff) < NUM_VERTICES);
   assign hb_ok  = (32'(hb_ff) < NUM_VERTICES);
   assign full   = (cnt_rd_a >= CNT_W'(MAX_LABELS));

   // List lengths, indexed by vertex.
   always_comb begin
      cnt_we    = 1'b0;
      cnt_waddr = va_idx;
      cnt_wdata = '0;
      if (cmd.clr_sweep) begin
         cnt_we    = 1'b1;
         cnt_waddr = clr_cnt_ff;
      end else if (cmd.wr_clear) begin
         cnt_we = va_ok;
      end else if (cmd.app_commit) begin
         cnt_we    = va_ok && !full;
         cnt_wdata = cnt_rd_a + CNT_W'(1);
      end
   end

   hlmdq_ram #(.WIDTH(CNT_W), .DEPTH(NUM_VERTICES)) u_count_ram (
      .clock     (clock),
      .wr_en     (cnt_we),
      .wr_addr   (cnt_waddr),
      .wr_data   (cnt_wdata),
      .rd_addr_a (va_idx),
      .rd_data_a (cnt_rd_a),
      .rd_addr_b (vb_idx),
      .rd_data_b (cnt_rd_b)
   );

   // Label entries, addressed by vertex and list position.
   assign lbl_we      = cmd.app_commit && va_ok && !full;
   assign lbl_waddr   = {va_idx, cnt_rd_a[LBL_W-1:0]};
   assign lbl_raddr_a = {va_idx, i_ff[LBL_W-1:0]};
   assign lbl_raddr_b = {vb_idx, j_ff[LBL_W-1:0]};

   hlmdq_ram #(.WIDTH(VERT_W), .DEPTH(LDEPTH)) u_hub_ram (
      .clock     (clock),
      .wr_en     (lbl_we),
      .wr_addr   (lbl_waddr),
      .wr_data   (hub_ff),
      .rd_addr_a (lbl_raddr_a),
      .rd_data_a (hub_rd_a),
      .rd_addr_b (lbl_raddr_b),
      .rd_data_b (hub_rd_b)
   );

   hlmdq_ram #(.WIDTH(DIST_BITS), .DEPTH(LDEPTH)) u_dist_ram (
      .clock     (clock),
      .wr_en     (lbl_we),
      .wr_addr   (lbl_waddr),
      .wr_data   (hd_ff),
      .rd_addr_a (lbl_raddr_a),
      .rd_data_a (dist_rd_a),
      .rd_addr_b (lbl_raddr_b),
      .rd_data_b (dist_rd_b)
   );

   // Vertex ranks, looked up with the hubs just read from the label store.
   hlmdq_ram #(.WIDTH(RANK_W), .DEPTH(NUM_VERTICES)) u_rank_ram (
      .clock     (clock),
      .wr_en     (cmd.wr_rank && va_ok),
      .wr_addr   (va_idx),
      .wr_data   (rank_ff),
      .rd_addr_a (VIDX_W'(hub_rd_a)),
      .rd_data_a (rank_rd_a),
      .rd_addr_b (VIDX_W'(hub_rd_b)),
      .rd_data_b (rank_rd_b)
   );

   // A hub outside the vertex range has rank zero.
   assign rank_a = ha_ok ? rank_rd_a : '0;
   assign rank_b = hb_ok ? rank_rd_b : '0;

   // Next values of all datapath registers.
   always_comb begin
      op_in         = op_ff;
      va_in         = va_ff;
      vb_in         = vb_ff;
      hub_in        = hub_ff;
      hd_in         = hd_ff;
      rank_in       = rank_ff;
      na_in         = na_ff;
      nb_in         = nb_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      ha_in         = ha_ff;
      hb_in         = hb_ff;
      sum_in        = sum_ff;
      best_in       = best_ff;
      found_in      = found_ff;
      status_in     = status_ff;
      clr_cnt_in    = clr_cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;

      if (cmd.clr_sweep) begin
         clr_cnt_in = clr_cnt_ff + VIDX_W'(1);
      end

      // Unpack and hold the request word.
      if (cmd.load_item) begin
         op_in     = op_type'(req_tuser);
         va_in     = req_tdata[VA_LSB +: VERT_W];
         vb_in     = req_tdata[VB_LSB +: VERT_W];
         hub_in    = req_tdata[HUB_LSB +: VERT_W];
         hd_in     = req_tdata[HDIST_LSB +: DIST_BITS];
         rank_in   = req_tdata[RANK_LSB +: RANK_W];
         best_in   = (op_type'(req_tuser) == OP_QUERY) ? SUM_ALL_ONES : '0;
         found_in  = 1'b0;
         status_in = 1'b0;
      end

      // An append dropped because the list is full is flagged.
      if (cmd.app_commit && va_ok && full) begin
         status_in = 1'b1;
      end

      // List lengths; an out-of-range vertex has an empty list.
      if (cmd.q_init) begin
         na_in = (32'(va_ff) < NUM_VERTICES) ? cnt_rd_a : '0;
         nb_in = (32'(vb_ff) < NUM_VERTICES) ? cnt_rd_b : '0;
         i_in  = '0;
         j_in  = '0;
      end

      // Hold both hubs and the candidate sum.
      if (cmd.q_latch) begin
         ha_in  = hub_rd_a;
         hb_in  = hub_rd_b;
         sum_in = {1'b0, dist_rd_a} + {1'b0, dist_rd_b};
      end

      // One merge step: common hub, or advance the side with the lower rank (side b on a tie).
      if (cmd.q_step) begin
         if (ha_ff == hb_ff) begin
            if (sum_ff < best_ff) begin
               best_in = sum_ff;
            end
            found_in = 1'b1;
            i_in     = i_ff + CNT_W'(1);
            j_in     = j_ff + CNT_W'(1);
         end else if (rank_a < rank_b) begin
            i_in = i_ff + CNT_W'(1);
         end else begin
            j_in = j_ff + CNT_W'(1);
         end
      end

      // Response register.
      if (cmd.load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_dist_in   = best_ff;
         rsp_found_in  = found_ff;
         rsp_status_in = status_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      va_ff         <= va_in;
      vb_ff         <= vb_in;
      hub_ff        <= hub_in;
      hd_ff         <= hd_in;
      rank_ff       <= rank_in;
      na_ff         <= na_in;
      nb_ff         <= nb_in;
      i_ff          <= i_in;
      j_ff          <= j_in;
      ha_ff         <= ha_in;
      hb_ff         <= hb_in;
      sum_ff        <= sum_in;
      best_ff       <= best_in;
      found_ff      <= found_in;
      status_ff     <= status_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Status to the controller.
   assign stat.op       = op_ff;
   assign stat.more     = (i_ff < na_ff) && (j_ff < nb_ff);
   assign stat.clr_last = (32'(clr_cnt_ff) == NUM_VERTICES - 1);
   assign stat.rsp_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_status_ff, rsp_found_ff, rsp_dist_ff});

endmodule

`default_nettype wire

FILE: design/hub_label_merge_distance_query_core.sv
// Top level of the hub-label distance query core: controller plus datapath.
// Set rank and clear pass through the exec state, append through the read and write states,
// and a query through S merge steps (at most 2*MAX_LABELS - 1) of fetch, hub and step states.
// One word is in flight at a time: the next request is taken in the cycle after its response
// is loaded, even while that response waits on rsp_tready.
// After reset all 1024 list lengths are cleared one vertex per cycle, with req_tready low.
`timescale 1ns / 1ps
`default_nettype none

module hub_label_merge_distance_query_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // req_tdata: vertex_a, vertex_b, hub_vertex, hub_distance, rank_value
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [hlmdq_pkg::REQ_W-1:0] req_tdata,
   // req_tuser: op
   input  wire logic [hlmdq_pkg::OP_W-1:0]  req_tuser,
   // rsp_tdata: distance, found, status, zero fill
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic      [hlmdq_pkg::RSP_W-1:0] rsp_tdata
);
   import hlmdq_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   hlmdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   hlmdq_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

`default_nettype wire

FILE: design/hlmdq_checker.sv
// Port-level checks for the hub-label distance query core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module hlmdq_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_tvalid,
   input wire logic                        req_tready,
   input wire logic                        rsp_tvalid,
   input wire logic                        rsp_tready,
   input wire logic [hlmdq_pkg::RSP_W-1:0] rsp_tdata
);
   import hlmdq_pkg::*;

   // Reset starts the length sweep: no request taken and no response shown.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("request or response active right after reset");

   // One word at a time: an accepted request closes the input side.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while another is in progress");

   // A stalled response keeps its word.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // A found query never carries the append-dropped flag.
   a_found_no_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[FOUND_POS] |-> !rsp_tdata[STATUS_POS])
      else $error("found and dropped flags both set");

   // Without a common hub the distance is all ones (query) or zero (other words).
   a_not_found_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[FOUND_POS] |->
         (rsp_tdata[SUM_W-1:0] == SUM_ALL_ONES) || (rsp_tdata[SUM_W-1:0] == '0))
      else $error("distance without a common hub is malformed");

endmodule

bind hub_label_merge_distance_query_core hlmdq_checker u_checker (.*);

`default_nettype wire
